// ----- sv/fmm_pkg.sv -----
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types, element table and helper functions for the formula
// monoisotopic mass block.
// ----------------------------------------------------------------------------
package fmm_pkg;

  localparam int CHAR_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int MASS_OUT_W = 64;
  localparam int WHOLE_W    = 7;
  localparam int NUM_ELEM   = 30;
  localparam int ROM_DEPTH  = 32;
  localparam int ROM_AW     = 5;

  // Decimal fraction scale of the element table (units of 1e-11)
  localparam logic [63:0] DEC_SCALE = 64'd100000000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_BADCHAR,
    ST_UNKNOWN,
    ST_COUNTBIG,
    ST_ZEROCOUNT,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_SYMBOL,
    PH_COUNT
  } phase_t;

  typedef logic [ROM_AW-1:0] rom_addr_t;

  typedef struct packed {
    logic      found;
    rom_addr_t idx;
  } lookup_t;

  // Element symbols: first letter, second letter (zero for one-letter symbols)
  localparam logic [7:0] SYM_FIRST [NUM_ELEM] = '{
    8'h48, 8'h48, 8'h4C, 8'h42, 8'h42, 8'h43, 8'h4E, 8'h4F, 8'h46, 8'h4E,
    8'h4E, 8'h4D, 8'h41, 8'h53, 8'h50, 8'h53, 8'h43, 8'h41, 8'h4B, 8'h43,
    8'h4D, 8'h46, 8'h43, 8'h4E, 8'h43, 8'h5A, 8'h53, 8'h42, 8'h4D, 8'h49
  };

  localparam logic [7:0] SYM_SECOND [NUM_ELEM] = '{
    8'h00, 8'h65, 8'h69, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65,
    8'h61, 8'h67, 8'h6C, 8'h69, 8'h00, 8'h00, 8'h6C, 8'h72, 8'h00, 8'h61,
    8'h6E, 8'h65, 8'h6F, 8'h69, 8'h75, 8'h6E, 8'h65, 8'h72, 8'h6F, 8'h00
  };

  localparam logic [7:0] MASS_WHOLE [NUM_ELEM] = '{
    8'd1,  8'd4,  8'd7,  8'd9,  8'd11, 8'd12, 8'd14, 8'd15, 8'd18, 8'd19,
    8'd22, 8'd23, 8'd26, 8'd27, 8'd30, 8'd31, 8'd34, 8'd39, 8'd38, 8'd39,
    8'd54, 8'd55, 8'd58, 8'd57, 8'd62, 8'd63, 8'd79, 8'd78, 8'd97, 8'd126
  };

  localparam logic [63:0] MASS_FRAC [NUM_ELEM] = '{
    64'd782503207,   64'd260325415,   64'd1600455000,  64'd1218220000,
    64'd930540000,   64'd0,           64'd307400480,   64'd99491461956,
    64'd99840322000, 64'd99244017540, 64'd98976928090, 64'd98504170000,
    64'd98153863000, 64'd97692653250, 64'd97376163000, 64'd97207100000,
    64'd96885268000, 64'd96238312250, 64'd96370668000, 64'd96259098000,
    64'd93804510000, 64'd93493750000, 64'd93319500000, 64'd93534290000,
    64'd92959750000, 64'd92914220000, 64'd91652130000, 64'd91833710000,
    64'd90540820000, 64'd90447300000
  };

  // Fixed-point mass of one element, rounded half up; constant use only
  function automatic logic [63:0] mass_fixed(input int k, input int frac_bits);
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    q = 64'(MASS_WHOLE[k]);
    r = MASS_FRAC[k];
    for (i = 0; i < frac_bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_SCALE) begin
        q = q | 64'd1;
        r = r - DEC_SCALE;
      end
    end
    if ((r << 1) >= DEC_SCALE) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  // Match a symbol against the table
  function automatic lookup_t sym_lookup(input logic [7:0] c1, input logic [7:0] c2);
    lookup_t res;
    int      k;
    res = '0;
    for (k = 0; k < NUM_ELEM; k++) begin
      if (!res.found && SYM_FIRST[k] == c1 && SYM_SECOND[k] == c2) begin
        res.found = 1'b1;
        res.idx   = rom_addr_t'(k);
      end
    end
    return res;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ----- sv/fmm_in_if.sv -----
// ----------------------------------------------------------------------------
// fmm_in_if
// Character channel: one formula character per transaction.
// ----------------------------------------------------------------------------
interface fmm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fmm_pkg::CHAR_W-1:0]  char_code;
  logic                        has_char;
  logic                        end_of_formula;

  modport source (output valid, output char_code, output has_char,
                  output end_of_formula, input ready);
  modport sink   (input valid, input char_code, input has_char,
                  input end_of_formula, output ready);
endinterface

// ----- sv/fmm_out_if.sv -----
// ----------------------------------------------------------------------------
// fmm_out_if
// Result channel: total mass and status, one transaction per formula.
// ----------------------------------------------------------------------------
interface fmm_out_if;
  logic                            valid;
  logic                            ready;
  logic [fmm_pkg::MASS_OUT_W-1:0]  formula_mass;
  logic [fmm_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output formula_mass, output status, input ready);
  modport sink   (input valid, input formula_mass, input status, output ready);
endinterface

// ----- sv/formula_monoisotopic_mass.sv -----
// ----------------------------------------------------------------------------
// formula_monoisotopic_mass
// Streams a chemical formula character by character and returns its summed
// monoisotopic mass in unsigned fixed point, with a status code.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while ready; it takes none
// during the table load or from the end_of_formula transaction until the
// formula is closed, in a closing cycle that finishes the last element.
// Element masses sit in a 32-entry RAM; a symbol lookup issues one RAM read,
// then a split multiply, a product merge and the accumulate into the output
// register follow. One result is in flight at a time: the closing cycle of a
// formula waits until the previous result has been taken, while its
// characters are still accepted. After reset a pass loads the mass table into
// the RAM, and no character is taken until it ends. The status is the first
// error met in stream order; formula_mass is zero for any status but ok.
// ----------------------------------------------------------------------------
module formula_monoisotopic_mass #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 24,
  parameter int TOTAL_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  fmm_in_if.sink    formula,
  fmm_out_if.source result
);

  import fmm_pkg::*;

  localparam int MASS_W  = WHOLE_W + FRAC_BITS;
  localparam int LO_W    = (MASS_W + 1) / 2;
  localparam int HI_W    = MASS_W - LO_W;
  localparam int PROD_W  = MASS_W + COUNT_BITS;
  localparam int SUM_W   = ((PROD_W > TOTAL_BITS) ? PROD_W : TOTAL_BITS) + 1;
  localparam int CNUM_W  = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE     = COUNT_BITS'(1);
  localparam logic [CNUM_W-1:0]     COUNT_MAX_EXT = {4'b0, {COUNT_BITS{1'b1}}};

  typedef struct packed {
    logic                  ev;
    logic                  fin;
    status_t               stat;
    logic [COUNT_BITS-1:0] cnt;
  } s1_t;

  typedef struct packed {
    logic                       ev;
    logic                       fin;
    status_t                    stat;
    logic [LO_W+COUNT_BITS-1:0] pp_lo;
    logic [HI_W+COUNT_BITS-1:0] pp_hi;
  } s2_t;

  typedef struct packed {
    logic              ev;
    logic              fin;
    status_t           stat;
    logic [PROD_W-1:0] prod;
  } s3_t;

  // Mass table constants, worked out at elaboration
  logic [MASS_W-1:0] rom_table [NUM_ELEM];

  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_rom
    localparam logic [63:0] MASS_G = mass_fixed(g, FRAC_BITS);
    assign rom_table[g] = MASS_G[MASS_W-1:0];
  end

  // Table load after reset
  logic      filling;
  rom_addr_t fill_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      filling  <= 1'b1;
      fill_idx <= '0;
    end else if (filling) begin
      fill_idx <= fill_idx + rom_addr_t'(1);
      if (fill_idx == rom_addr_t'(NUM_ELEM - 1)) begin
        filling <= 1'b0;
      end
    end
  end

  // Parser state
  phase_t                phase, phase_next;
  logic [7:0]            sym_first, sym_first_next;
  logic [7:0]            sym_second, sym_second_next;
  logic [1:0]            sym_len, sym_len_next;
  logic [COUNT_BITS-1:0] count_value, count_value_next;
  logic                  chars_seen, chars_seen_next;
  status_t               parse_err, parse_err_next;
  logic                  pend_end, pend_end_next;
  logic                  outstanding, outstanding_next;

  logic              take;
  logic              out_take;
  logic              end_go;
  logic              go_start;
  logic [7:0]        c;
  logic              c_up, c_low, c_dig;
  lookup_t           look;
  logic              sym_ok;
  logic [CNUM_W-1:0] cnt_ext;
  logic [CNUM_W-1:0] cnt_mul;
  s1_t               tok;
  rom_addr_t         tok_idx;

  assign take     = formula.valid && formula.ready;
  assign out_take = result.valid && result.ready;
  assign end_go   = pend_end && (!outstanding || out_take);

  assign formula.ready = !filling && !pend_end;

  assign c       = formula.char_code;
  assign c_up    = is_upper(c);
  assign c_low   = is_lower(c);
  assign c_dig   = is_digit(c);
  assign look    = sym_lookup(sym_first, sym_second);
  assign sym_ok  = look.found && (sym_len != 2'd3);
  assign tok_idx = look.idx;
  assign cnt_ext = {4'b0, count_value};
  assign cnt_mul = (cnt_ext << 3) + (cnt_ext << 1) + CNUM_W'(c[3:0]);

  // Parse one character, or close the formula once its end has been taken and no earlier result is outstanding
  always_comb begin
    phase_next       = phase;
    sym_first_next   = sym_first;
    sym_second_next  = sym_second;
    sym_len_next     = sym_len;
    count_value_next = count_value;
    chars_seen_next  = chars_seen;
    parse_err_next   = parse_err;
    pend_end_next    = pend_end;
    go_start         = 1'b0;
    tok              = '0;
    tok.stat         = parse_err;

    if (end_go) begin
      // Close the last element and hand the final token on
      tok.fin          = 1'b1;
      pend_end_next    = 1'b0;
      phase_next       = PH_START;
      sym_first_next   = '0;
      sym_second_next  = '0;
      sym_len_next     = '0;
      count_value_next = '0;
      chars_seen_next  = 1'b0;
      parse_err_next   = ST_OK;
      if (!chars_seen) begin
        tok.stat = ST_EMPTY;
      end else if (parse_err == ST_OK) begin
        case (phase)
          PH_SYMBOL: begin
            if (sym_ok) begin
              tok.ev  = 1'b1;
              tok.cnt = COUNT_ONE;
            end else begin
              tok.stat = ST_UNKNOWN;
            end
          end
          PH_COUNT: begin
            if (count_value == '0) begin
              tok.stat = ST_ZEROCOUNT;
            end else begin
              tok.ev  = 1'b1;
              tok.cnt = count_value;
            end
          end
          default: begin
            tok.stat = ST_OK;
          end
        endcase
      end
    end else if (take) begin
      if (formula.end_of_formula) begin
        pend_end_next = 1'b1;
      end
      if (formula.has_char) begin
        chars_seen_next = 1'b1;
        if (parse_err == ST_OK) begin
          case (phase)
            PH_SYMBOL: begin
              if (c_low) begin
                if (sym_len == 2'd1) begin
                  sym_second_next = c;
                end
                if (sym_len != 2'd3) begin
                  sym_len_next = sym_len + 2'd1;
                end
              end else if (!sym_ok) begin
                parse_err_next = ST_UNKNOWN;
              end else if (c_dig) begin
                count_value_next = COUNT_BITS'(c[3:0]);
                phase_next       = PH_COUNT;
              end else begin
                tok.ev   = 1'b1;
                tok.cnt  = COUNT_ONE;
                go_start = 1'b1;
              end
            end
            PH_COUNT: begin
              if (c_dig) begin
                if (cnt_mul > COUNT_MAX_EXT) begin
                  parse_err_next = ST_COUNTBIG;
                end else begin
                  count_value_next = cnt_mul[COUNT_BITS-1:0];
                end
              end else if (count_value == '0) begin
                parse_err_next = ST_ZEROCOUNT;
              end else begin
                tok.ev   = 1'b1;
                tok.cnt  = count_value;
                go_start = 1'b1;
              end
            end
            default: begin
              go_start = 1'b1;
            end
          endcase
          // Open a new element, or flag the character
          if (go_start) begin
            if (c_up) begin
              sym_first_next  = c;
              sym_second_next = '0;
              sym_len_next    = 2'd1;
              phase_next      = PH_SYMBOL;
            end else begin
              parse_err_next = ST_BADCHAR;
            end
          end
        end
      end
    end
  end

  // One result in flight: set on closing, drop when taken
  always_comb begin
    outstanding_next = outstanding;
    if (end_go) begin
      outstanding_next = 1'b1;
    end else if (out_take) begin
      outstanding_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      sym_first   <= '0;
      sym_second  <= '0;
      sym_len     <= '0;
      count_value <= '0;
      chars_seen  <= 1'b0;
      parse_err   <= ST_OK;
      pend_end    <= 1'b0;
      outstanding <= 1'b0;
    end else begin
      phase       <= phase_next;
      sym_first   <= sym_first_next;
      sym_second  <= sym_second_next;
      sym_len     <= sym_len_next;
      count_value <= count_value_next;
      chars_seen  <= chars_seen_next;
      parse_err   <= parse_err_next;
      pend_end    <= pend_end_next;
      outstanding <= outstanding_next;
    end
  end

  // Mass RAM: loaded once, then read per element
  logic [MASS_W-1:0] ram_rdata;

  fmm_ram #(
    .WIDTH (MASS_W),
    .DEPTH (ROM_DEPTH)
  ) u_mass_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_idx),
    .wdata (rom_table[fill_idx]),
    .re    (tok.ev),
    .raddr (tok_idx),
    .rdata (ram_rdata)
  );

  // Stage 1: hold the token while the RAM read completes
  s1_t s1;
  s2_t s2;
  s3_t s3;

  logic [LO_W-1:0]            m_lo;
  logic [HI_W-1:0]            m_hi;
  logic [LO_W+COUNT_BITS-1:0] pp_lo_c;
  logic [HI_W+COUNT_BITS-1:0] pp_hi_c;

  assign m_lo    = ram_rdata[LO_W-1:0];
  assign m_hi    = ram_rdata[MASS_W-1:LO_W];
  assign pp_lo_c = {{COUNT_BITS{1'b0}}, m_lo} * {{LO_W{1'b0}}, s1.cnt};
  assign pp_hi_c = {{COUNT_BITS{1'b0}}, m_hi} * {{HI_W{1'b0}}, s1.cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.ev  <= 1'b0;
      s1.fin <= 1'b0;
      s2.ev  <= 1'b0;
      s2.fin <= 1'b0;
      s3.ev  <= 1'b0;
      s3.fin <= 1'b0;
    end else begin
      s1.ev  <= tok.ev;
      s1.fin <= tok.fin;
      s2.ev  <= s1.ev;
      s2.fin <= s1.fin;
      s3.ev  <= s2.ev;
      s3.fin <= s2.fin;
    end
    // Advance payloads: split multiply, then merge the partial products
    s1.stat  <= tok.stat;
    s1.cnt   <= tok.cnt;
    s2.stat  <= s1.stat;
    s2.pp_lo <= pp_lo_c;
    s2.pp_hi <= pp_hi_c;
    s3.stat  <= s2.stat;
    s3.prod  <= (PROD_W'(s2.pp_hi) << LO_W) + PROD_W'(s2.pp_lo);
  end

  // Accumulate with overflow check
  logic [TOTAL_BITS-1:0] total;
  logic                  arith_err;
  logic [SUM_W-1:0]      sum;
  logic                  ovf;
  logic [TOTAL_BITS-1:0] total_add;
  logic                  arith_now;
  status_t               fin_stat;

  assign sum       = SUM_W'(total) + SUM_W'(s3.prod);
  assign ovf       = s3.ev && (sum[SUM_W-1:TOTAL_BITS] != '0);
  assign total_add = (s3.ev && !ovf) ? sum[TOTAL_BITS-1:0] : total;
  assign arith_now = arith_err || ovf;
  assign fin_stat  = arith_now ? ST_OVERFLOW : s3.stat;

  // Output register
  logic                  out_valid;
  logic [MASS_OUT_W-1:0] out_mass;
  status_t               out_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      arith_err <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      if (s3.fin) begin
        out_valid <= 1'b1;
        total     <= '0;
        arith_err <= 1'b0;
      end else begin
        total     <= total_add;
        arith_err <= arith_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3.fin) begin
      out_mass <= (fin_stat == ST_OK) ? MASS_OUT_W'(total_add) : '0;
      out_stat <= fin_stat;
    end
  end

  assign result.valid        = out_valid;
  assign result.formula_mass = out_mass;
  assign result.status       = out_stat;

  // A final token never lands on an occupied output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    s3.fin |-> !out_valid)
    else $error("final token reached a full output register");

  // Every final token in the pipe was granted a result slot
  a_fin_credit: assert property (@(posedge clk) disable iff (rst)
    s3.fin |-> outstanding)
    else $error("final token without an outstanding result");

  // No element is looked up while the table is still loading
  a_no_lookup_fill: assert property (@(posedge clk) disable iff (rst)
    filling |-> !tok.ev && !tok.fin)
    else $error("token issued during the table load");

endmodule

// ----- sv/fmm_ram.sv -----
// ----------------------------------------------------------------------------
// fmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
